// ===== hdl/epc_pkg.sv =====
// package: shared constants, codes and state type for the encoder period tachometer
`default_nettype none
package epc_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam logic [15:0] PPR_RESET = 16'd20;
  localparam logic [63:0] US_RPM_Q4 = 64'd960000000;

  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_QMUL,
    ST_QCHK,
    ST_QDIV,
    ST_QOUT
  } epc_state_t;

endpackage
`default_nettype wire

// ===== hdl/epc_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none
module epc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/epc_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module epc_div #(
  parameter int unsigned NUM_W = 33,
  parameter int unsigned DEN_W = 54
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int unsigned REM_W = DEN_W + 1;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [REM_W-1:0] rem;
  logic [NUM_W-1:0] nq;
  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [REM_W-1:0] shifted;
  logic             ge;

  assign shifted = {rem[REM_W-2:0], nq[NUM_W-1]};
  assign ge      = shifted >= REM_W'(dreg);
  assign quo     = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      nq   <= num;
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? (shifted - REM_W'(dreg)) : shifted;
      nq  <= {nq[NUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/encoder_period_tachometer_unit.sv =====
// top level: encoder period ring, running sum, query sequencer and output register
//
// Input channel (in_valid/in_stall, operation, time_us): an edge item (operation 0)
// stores the period since the previous edge in a ring of DEPTH entries and keeps a
// running sum of the ring; it passes through ST_EDGE and gives no result. A query item
// (operation 1) gives one result on the output channel (out_valid/out_stall,
// speed_rpm_q4) in 1/16 rpm: zero with no data or when stalled, else
// 960e6*DEPTH/(pulses_per_rev*sum) saturated to 32 bits.
// A query that runs the divider goes through the multiply and the check, then the
// divider, which gives one quotient bit per numerator bit (33 at DEPTH 8), then takes
// the quotient and loads the output; the next item is taken once it is back in idle.
// A query that answers without the divider goes from the check straight to the output
// load, and the next item is taken in the same way.
// in_stall is high while an item is being worked on. A finished result waits in the
// output register; the next item is taken while it waits, but a further result is
// held back until the receiver lifts out_stall.
// Configuration (cfg_valid/cfg_ready, cfg_data) writes pulses_per_rev; always ready.
// Reset clears the ring (a fill flag makes unwritten entries read as zero), the
// running sum, slot, last edge time and sets pulses_per_rev to 20.
`default_nettype none
module encoder_period_tachometer_unit #(
  parameter int unsigned DEPTH = epc_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [31:0] time_us,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] speed_rpm_q4,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  import epc_pkg::*;

  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DW     = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = 32 + DW;
  localparam int unsigned PROD_W = 32 + DW;
  localparam int unsigned CMP_W  = SUM_W + 1;
  localparam int unsigned DEN_W  = 16 + SUM_W;
  localparam logic [63:0] NUM_VAL = US_RPM_Q4 * DEPTH;
  localparam int unsigned NUM_W  = $clog2(NUM_VAL + 64'd1);
  localparam int unsigned QX_W   = (NUM_W > 33) ? NUM_W : 33;

  epc_state_t state, state_next;

  logic [15:0]       ppr;
  logic [AW-1:0]     slot;
  logic              full;
  logic [31:0]       last_edge_time;
  logic [SUM_W-1:0]  sum;
  logic [31:0]       period;
  logic [31:0]       elapsed;
  logic [PROD_W-1:0] el_prod;
  logic [DEN_W-1:0]  den;
  logic [31:0]       old_period;
  logic [31:0]       result, result_next;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  quo;
  logic [QX_W-1:0]   quo_x;
  logic              in_acc;
  logic              out_load;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign quo_x     = QX_W'(quo);

  epc_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state == ST_EDGE),
    .wr_addr (slot),
    .wr_data (period),
    .rd_addr (slot),
    .rd_data (old_period)
  );

  epc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (NUM_W'(NUM_VAL)),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    div_start   = 1'b0;
    out_load    = 1'b0;
    result_next = result;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (operation == OP_EDGE) ? ST_EDGE : ST_QMUL;
        end
      end
      ST_EDGE: begin
        state_next = ST_IDLE;
      end
      ST_QMUL: begin
        state_next = ST_QCHK;
      end
      ST_QCHK: begin
        if (sum == '0) begin
          result_next = '0;
          state_next  = ST_QOUT;
        end else if (CMP_W'(el_prod) > CMP_W'({sum, 1'b0})) begin
          result_next = '0;
          state_next  = ST_QOUT;
        end else if (ppr == '0) begin
          result_next = '1;
          state_next  = ST_QOUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_QDIV;
        end
      end
      ST_QDIV: begin
        if (div_done) begin
          result_next = (|quo_x[QX_W-1:32]) ? '1 : quo_x[31:0];
          state_next  = ST_QOUT;
        end
      end
      ST_QOUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ppr            <= PPR_RESET;
      slot           <= '0;
      full           <= 1'b0;
      last_edge_time <= '0;
      sum            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ppr <= cfg_data;
      end
      if (in_acc && operation == OP_EDGE) begin
        last_edge_time <= time_us;
      end
      if (state == ST_EDGE) begin
        sum <= sum - (full ? SUM_W'(old_period) : '0) + SUM_W'(period);
        if (slot == AW'(DEPTH - 1)) begin
          slot <= '0;
          full <= 1'b1;
        end else begin
          slot <= slot + 1'b1;
        end
      end
      out_valid <= out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      period  <= time_us - last_edge_time;
      elapsed <= time_us - last_edge_time;
    end
    if (state == ST_QMUL) begin
      el_prod <= PROD_W'(elapsed) * PROD_W'(DEPTH);
      den     <= DEN_W'(ppr) * DEN_W'(sum);
    end
    result <= result_next;
    if (out_load) begin
      speed_rpm_q4 <= result_next;
    end
  end

  a_edge_two_cycles: assert property (@(posedge clk) disable iff (rst)
    (in_acc && operation == OP_EDGE) |=> (state == ST_EDGE) ##1 (state == ST_IDLE))
    else $error("edge item did not finish in two cycles");

  a_div_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QDIV && div_done) |=> (state == ST_QOUT))
    else $error("divider result not taken");

  a_ring_full_wrap: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> (slot == '0))
    else $error("ring marked full away from slot zero");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == ST_IDLE))
    else $error("result not presented after load");

endmodule
`default_nettype wire
